// File: hdl/bm3_pkg.sv
`timescale 1ns / 1ps

package bm3_pkg;

   // Default geometry limits of the line store and the row counter
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FG_MASK  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BG_MASK  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT   = 3'd4;

   // Register widths and reset values
   localparam int MODE_W   = 2;
   localparam int MASK_W   = 9;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 13;
   localparam logic [MODE_W-1:0]   MODE_RST   = 2'd0;
   localparam logic [MASK_W-1:0]   FG_RST     = 9'd511;
   localparam logic [MASK_W-1:0]   BG_RST     = 9'd0;
   localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

   // Operation modes
   localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HITMISS = 2'd2;

   // Input item kinds
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam int PIX_W = 8;
   localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
   localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

   // In-image flags for the column held by one window cell
   typedef struct packed {
      logic       col_ok;
      logic [2:0] row_ok;   // bit 0 row above, bit 1 own row, bit 2 row below
   } cell_ok_type;

   // Partial verdict of one window column
   typedef struct packed {
      logic fg_miss;   // a foreground-mask neighbour is clear or outside
      logic fg_any;    // a foreground-mask neighbour is set and inside
      logic bg_any;    // a background-mask neighbour is set and inside
   } cell_part_type;

endpackage

// File: hdl/binary_morphology_3x3.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_      in         req_tvalid/tready    tdata[0] pixel_set, tuser command
// rsp_      out        rsp_tvalid/tready    tdata[7:0] pixel_out, tlast frame_end
// csr_      in         csr_wr_en            csr_index, csr_wdata
//
// One item per clock, back to back while req_tready is high: window step, line store write,
// read-ahead of the next column and verdict all happen in the cycle the item is accepted.
// A result sits in the output register from the cycle after its item is accepted;
// req_tready drops only while that register is full and rsp_tready is low.
// Synchronous reset clears counters, frame flag, output valid flag and configuration registers;
// the line store is left as is, as stale rows only land on outside neighbours.
module binary_morphology_3x3 #(
   parameter int MAX_WIDTH  = bm3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bm3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // input items
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [0] pixel_set, rest zero
   input  logic                             req_tuser,   // [0] command
   // result items
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,   // [7:0] pixel_out
   output logic                             rsp_tlast,   // frame_end
   // configuration writes
   input  logic                             csr_wr_en,
   input  logic [bm3_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bm3_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);        // column index
   localparam int HW = $clog2(MAX_HEIGHT);       // output row index
   localparam int RW = $clog2(MAX_HEIGHT + 3);   // input row, runs past the frame while draining

   // Configuration registers
   logic [bm3_pkg::MODE_W-1:0]   mode_ff;
   logic [bm3_pkg::MASK_W-1:0]   fg_ff;
   logic [bm3_pkg::MASK_W-1:0]   bg_ff;
   logic [bm3_pkg::WIDTH_W-1:0]  width_ff;
   logic [bm3_pkg::HEIGHT_W-1:0] height_ff;

   // Frame control
   logic          active_ff, active_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] ocol_ff, ocol_in;
   logic [HW-1:0] orow_ff, orow_in;
   logic [CW-1:0] wl_ff, wl_in;     // last column of the frame
   logic [HW-1:0] hl_ff, hl_in;     // last row of the frame

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_pix_ff;
   logic             rsp_last_ff;

   logic          acc, flush, start, pix_phase, adv, emit, done, hit;
   logic          bit_in, col_last;
   logic [31:0]   w32, h32;
   logic [CW-1:0] wl_new, wl_cur;
   logic [HW-1:0] hl_new, hl_cur;
   logic [1:0]    line_q;
   logic [2:0]    new_col;

   logic [2:0]                  cell_in   [3];
   logic [2:0]                  cell_q    [3];
   bm3_pkg::cell_ok_type        cell_ok   [3];
   bm3_pkg::cell_part_type      cell_part [3];
   logic [2:0]                  col_ok;
   logic [2:0]                  row_ok;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= bm3_pkg::MODE_RST;
         fg_ff     <= bm3_pkg::FG_RST;
         bg_ff     <= bm3_pkg::BG_RST;
         width_ff  <= bm3_pkg::WIDTH_RST;
         height_ff <= bm3_pkg::HEIGHT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            bm3_pkg::REG_MODE:    mode_ff   <= csr_wdata[bm3_pkg::MODE_W-1:0];
            bm3_pkg::REG_FG_MASK: fg_ff     <= csr_wdata[bm3_pkg::MASK_W-1:0];
            bm3_pkg::REG_BG_MASK: bg_ff     <= csr_wdata[bm3_pkg::MASK_W-1:0];
            bm3_pkg::REG_WIDTH:   width_ff  <= csr_wdata[bm3_pkg::WIDTH_W-1:0];
            bm3_pkg::REG_HEIGHT:  height_ff <= csr_wdata[bm3_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the programmed geometry into the range the buffers cover
   assign w32 = 32'(width_ff);
   assign h32 = 32'(height_ff);
   assign wl_new = (w32 == 32'd0) ? '0 :
                   (w32 > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) : CW'(w32 - 32'd1);
   assign hl_new = (h32 == 32'd0) ? '0 :
                   (h32 > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT - 1) : HW'(h32 - 32'd1);

   // Accept whenever the output register is free or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign acc        = req_tvalid && req_tready;
   assign flush      = (req_tuser == bm3_pkg::CMD_FLUSH);
   assign start      = !active_ff && !flush;

   // The first pixel of a frame uses the freshly latched geometry
   assign wl_cur    = active_ff ? wl_ff : wl_new;
   assign hl_cur    = active_ff ? hl_ff : hl_new;
   assign pix_phase = (row_ff <= RW'(hl_cur));

   // Drop flushes that come too early; treat surplus pixels as flushes
   assign adv      = acc && (active_ff || !flush) && !(pix_phase && flush);
   assign bit_in   = pix_phase && req_tdata[0];
   assign col_last = (col_ff == wl_cur);
   assign emit     = adv && ((row_ff >= RW'(2)) || ((row_ff == RW'(1)) && (col_ff != '0)));
   assign done     = (orow_ff == hl_cur) && (ocol_ff == wl_cur);

   always_comb begin
      active_in = active_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;
      wl_in     = wl_ff;
      hl_in     = hl_ff;
      if (acc && start) begin
         active_in = 1'b1;
         wl_in     = wl_new;
         hl_in     = hl_new;
      end
      if (adv) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (emit) begin
         if (done) begin
            // last result: go idle, the next pixel opens a new frame
            active_in = 1'b0;
            col_in    = '0;
            row_in    = '0;
            ocol_in   = '0;
            orow_in   = '0;
         end else if (ocol_ff == wl_cur) begin
            ocol_in = '0;
            orow_in = orow_ff + HW'(1);
         end else begin
            ocol_in = ocol_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
         wl_ff     <= '0;
         hl_ff     <= '0;
      end else begin
         active_ff <= active_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         ocol_ff   <= ocol_in;
         orow_ff   <= orow_in;
         wl_ff     <= wl_in;
         hl_ff     <= hl_in;
      end
   end

   // Line store: bit 1 holds the row two above, bit 0 the row above.
   // Read ahead at the column the next item will use.
   bm3_line_buf #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (adv),
      .wr_addr (col_ff),
      .wr_data ({line_q[0], bit_in}),
      .rd_addr (col_in),
      .rd_data (line_q)
   );

   // New window column: top, middle, bottom from bit 0 up
   assign new_col = {bit_in, line_q[0], line_q[1]};

   // Neighbours that lie inside the image for the current output position
   assign row_ok = {orow_ff != hl_cur, 1'b1, orow_ff != '0};
   assign col_ok = {ocol_ff != wl_cur, 1'b1, ocol_ff != '0};

   // Chain of window columns: the new column enters on the right, each
   // column moves one place left per step
   for (genvar k = 0; k < 3; k++) begin : g_cell
      if (k == 2) begin : g_head
         assign cell_in[k] = new_col;
      end else begin : g_link
         assign cell_in[k] = cell_q[k+1];
      end
      assign cell_ok[k].col_ok = col_ok[k];
      assign cell_ok[k].row_ok = row_ok;

      bm3_cell u_cell (
         .clock    (clock),
         .shift_en (adv),
         .col_in   (cell_in[k]),
         .fg_mask  ({fg_ff[6+k], fg_ff[3+k], fg_ff[k]}),
         .bg_mask  ({bg_ff[6+k], bg_ff[3+k], bg_ff[k]}),
         .ok       (cell_ok[k]),
         .col_q    (cell_q[k]),
         .part     (cell_part[k])
      );
   end

   // Combine the column verdicts for the selected operation
   always_comb begin
      case (mode_ff)
         bm3_pkg::MODE_ERODE:
            hit = !(cell_part[0].fg_miss || cell_part[1].fg_miss || cell_part[2].fg_miss);
         bm3_pkg::MODE_DILATE:
            hit = cell_part[0].fg_any || cell_part[1].fg_any || cell_part[2].fg_any;
         bm3_pkg::MODE_HITMISS:
            hit = !(cell_part[0].fg_miss || cell_part[1].fg_miss || cell_part[2].fg_miss)
               && !(cell_part[0].bg_any || cell_part[1].bg_any || cell_part[2].bg_any);
         default:
            hit = 1'b0;
      endcase
   end

   // Output register: load on a result, clear once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_pix_ff  <= hit ? bm3_pkg::PIX_ON : bm3_pkg::PIX_OFF;
         rsp_last_ff <= done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hdl/bm3_cell.sv
`timescale 1ns / 1ps

// One column of the 3x3 window: holds three pixels, passes them on at each step.
module bm3_cell (
   input  logic                  clock,
   input  logic                  shift_en,
   input  logic [2:0]            col_in,
   input  logic [2:0]            fg_mask,
   input  logic [2:0]            bg_mask,
   input  bm3_pkg::cell_ok_type  ok,
   output logic [2:0]            col_q,
   output bm3_pkg::cell_part_type part
);

   logic [2:0] col_ff;
   logic [2:0] on;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   // Judge the column that is about to be loaded
   assign on           = col_in & ok.row_ok & {3{ok.col_ok}};
   assign part.fg_miss = |(fg_mask & ~on);
   assign part.fg_any  = |(fg_mask & on);
   assign part.bg_any  = |(bg_mask & on);
   assign col_q        = col_ff;

endmodule

// File: hdl/bm3_line_buf.sv
`timescale 1ns / 1ps

// Two-row line store: one write and one registered read per cycle, with
// forwarding when the read hits the address written in the same cycle.
module bm3_line_buf #(
   parameter int DEPTH = bm3_pkg::MAX_WIDTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [1:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [1:0]    rd_data
);

   logic [1:0] mem [DEPTH];
   logic [1:0] mem_q_ff;
   logic [1:0] byp_data_ff;
   logic       byp_ff;
   logic       byp_in;

   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff    <= mem[rd_addr];
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : mem_q_ff;

endmodule
